/* rtl/pagerank_vertex_update_assert.svh */
// Assertion macros shared by the vertex update RTL.
`ifndef PAGERANK_VERTEX_UPDATE_ASSERT_SVH
`define PAGERANK_VERTEX_UPDATE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PRVU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PRVU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/prvu_pkg.sv */
// Types and constants of the PageRank vertex update block.
`timescale 1ns / 1ps

package prvu_pkg;

    localparam int unsigned FRAC_W  = 32;
    localparam int unsigned DEG_W   = 16;
    localparam int unsigned STEPS   = FRAC_W;
    localparam int unsigned STEP_W  = $clog2(STEPS);
    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        CMD_RECEIVE  = 2'd0,
        CMD_SEND     = 2'd1,
        CMD_END_ITER = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_DEGREE      = 8'd0,
        CFG_OUT_DEGREE     = 8'd1,
        CFG_DAMPING_OFFSET = 8'd2,
        CFG_DAMPING_GAIN   = 8'd3
    } cfg_idx_t;

    localparam logic [1:0] EVT_NONE  = 2'b00;
    localparam logic [1:0] EVT_RAISE = 2'b01;
    localparam logic [1:0] EVT_LOWER = 2'b10;

    typedef struct packed {
        logic done;
        logic all_rcvd;
        logic sent;
    } flags_t;

    // Status of a bit-serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

/* rtl/prvu_mul.sv */
// Bit-serial shift-add multiplier keeping the upper half of a 32x32 product.
`timescale 1ns / 1ps

module prvu_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [prvu_pkg::FRAC_W-1:0]  multiplicand,
    input  logic [prvu_pkg::FRAC_W-1:0]  multiplier,
    output prvu_pkg::unit_sts_t          sts,
    output logic [prvu_pkg::FRAC_W-1:0]  product_hi
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [prvu_pkg::STEP_W-1:0]   step_reg;
    logic [prvu_pkg::FRAC_W-1:0]   mcand_reg;
    logic [prvu_pkg::FRAC_W-1:0]   mplr_reg;
    logic [prvu_pkg::FRAC_W-1:0]   hi_reg;
    logic [prvu_pkg::FRAC_W:0]     sum;

    // Add the multiplicand when the current multiplier bit is set.
    assign sum = {1'b0, hi_reg}
               + (mplr_reg[0] ? {1'b0, mcand_reg} : {(prvu_pkg::FRAC_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == prvu_pkg::STEP_W'(prvu_pkg::STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= multiplicand;
            mplr_reg  <= multiplier;
            hi_reg    <= '0;
        end
        else if (busy_reg)
        begin
            // Shift the partial product right; low bits drop out.
            hi_reg   <= sum[prvu_pkg::FRAC_W:1];
            mplr_reg <= {1'b0, mplr_reg[prvu_pkg::FRAC_W-1:1]};
        end
    end

    assign sts.busy   = busy_reg;
    assign sts.done   = done_reg;
    assign product_hi = hi_reg;

endmodule

/* rtl/prvu_div.sv */
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, zero divisor passes through.
`timescale 1ns / 1ps

module prvu_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [prvu_pkg::FRAC_W-1:0]  dividend,
    input  logic [prvu_pkg::DEG_W-1:0]   divisor,
    output prvu_pkg::unit_sts_t          sts,
    output logic [prvu_pkg::FRAC_W-1:0]  quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [prvu_pkg::STEP_W-1:0]   step_reg;
    logic                          bypass_reg;
    logic [prvu_pkg::DEG_W-1:0]    dvsr_reg;
    logic [prvu_pkg::DEG_W-1:0]    rem_reg;
    logic [prvu_pkg::FRAC_W-1:0]   quot_reg;
    logic [prvu_pkg::DEG_W:0]      trial;
    logic [prvu_pkg::DEG_W:0]      diff;

    assign trial = {rem_reg, quot_reg[prvu_pkg::FRAC_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == prvu_pkg::STEP_W'(prvu_pkg::STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bypass_reg <= (divisor == '0);
            dvsr_reg   <= divisor;
            rem_reg    <= '0;
            quot_reg   <= dividend;
        end
        else if (busy_reg && !bypass_reg)
        begin
            // Keep the difference when it does not borrow, restore otherwise.
            if (!diff[prvu_pkg::DEG_W])
            begin
                rem_reg  <= diff[prvu_pkg::DEG_W-1:0];
                quot_reg <= {quot_reg[prvu_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[prvu_pkg::DEG_W-1:0];
                quot_reg <= {quot_reg[prvu_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quot_reg;

endmodule

/* rtl/pagerank_vertex_update.sv */
// Top level of the PageRank vertex update block.
`timescale 1ns / 1ps

// One vertex of an iterative PageRank. Each input transfer carries a command: receive adds
// an unsigned 0.32 contribution to the accumulator and counts it (all-received is flagged
// once the count reaches in_degree), send marks the vertex as sent (or finished at once when
// in_degree is zero), and end of iteration sets rank = damping_offset + upper half of
// damping_gain * accumulator, then clears accumulator, count and flags. Every command yields
// exactly one result transfer carrying rank, rank / out_degree (rank itself when out_degree
// is zero), the progress flags and the semaphore event the command caused. The block works
// on one item at a time: receive, send and no-op items pass through the 32-step bit-serial
// restoring divider that forms the broadcast share; end of iteration first runs the
// bit-serial shift-add multiplier ahead of the divider. A new input transfer is taken as
// soon as the previous result sits in the output register, even while that result is still
// waiting for out_ready. Configuration writes land at once and must only come while the block
// is idle.

module pagerank_vertex_update (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write_en,
    input  logic [prvu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prvu_pkg::FRAC_W-1:0]     cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [prvu_pkg::FRAC_W-1:0]     contribution,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [prvu_pkg::FRAC_W-1:0]     rank_value,
    output logic [prvu_pkg::FRAC_W-1:0]     broadcast_share,
    output logic                            should_send,
    output logic                            all_received,
    output logic                            sent_flag,
    output logic                            finished_flag,
    output logic [1:0]                      semaphore_event
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;

    logic [prvu_pkg::DEG_W-1:0]    in_degree_reg;
    logic [prvu_pkg::DEG_W-1:0]    out_degree_reg;
    logic [prvu_pkg::FRAC_W-1:0]   damping_offset_reg;
    logic [prvu_pkg::FRAC_W-1:0]   damping_gain_reg;

    logic [prvu_pkg::FRAC_W-1:0]   rank_reg, rank_next;
    logic [prvu_pkg::FRAC_W-1:0]   acc_reg, acc_next;
    logic [prvu_pkg::DEG_W-1:0]    count_reg, count_next;
    prvu_pkg::flags_t              flags_reg, flags_next;
    logic [1:0]                    evt_reg, evt_next;

    logic                          out_valid_reg, out_valid_next;
    logic [prvu_pkg::FRAC_W-1:0]   rank_out_reg;
    logic [prvu_pkg::FRAC_W-1:0]   share_out_reg;
    prvu_pkg::flags_t              flags_out_reg;
    logic [1:0]                    evt_out_reg;

    prvu_pkg::cmd_e_t              in_cmd;
    logic                          in_fire;
    logic                          out_load;

    logic                          mul_start;
    prvu_pkg::unit_sts_t           mul_sts;
    logic [prvu_pkg::FRAC_W-1:0]   mul_hi;
    logic [prvu_pkg::FRAC_W-1:0]   rank_sum;

    logic                          div_start;
    prvu_pkg::unit_sts_t           div_sts;
    logic [prvu_pkg::FRAC_W-1:0]   div_dividend;
    logic [prvu_pkg::FRAC_W-1:0]   div_quot;

    assign in_cmd   = prvu_pkg::cmd_e_t'(command);
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Hand the result over once the output register is free or being drained.
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // New rank at end of iteration: offset plus the truncated 0.32 product, wrapping.
    assign rank_sum = damping_offset_reg + mul_hi;

    assign mul_start    = in_fire && (in_cmd == prvu_pkg::CMD_END_ITER);
    assign div_start    = (in_fire && (in_cmd != prvu_pkg::CMD_END_ITER))
                       || ((state_reg == S_MUL) && mul_sts.done);
    assign div_dividend = (state_reg == S_MUL) ? rank_sum : rank_reg;

    prvu_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (damping_gain_reg),
        .multiplier   (acc_reg),
        .sts          (mul_sts),
        .product_hi   (mul_hi)
    );

    prvu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (out_degree_reg),
        .sts      (div_sts),
        .quotient (div_quot)
    );

    // Configuration registers; unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_degree_reg      <= '0;
            out_degree_reg     <= '0;
            damping_offset_reg <= '0;
            damping_gain_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                prvu_pkg::CFG_IN_DEGREE:
                    in_degree_reg <= cfg_data[prvu_pkg::DEG_W-1:0];
                prvu_pkg::CFG_OUT_DEGREE:
                    out_degree_reg <= cfg_data[prvu_pkg::DEG_W-1:0];
                prvu_pkg::CFG_DAMPING_OFFSET:
                    damping_offset_reg <= cfg_data;
                prvu_pkg::CFG_DAMPING_GAIN:
                    damping_gain_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Command decode and sequencing.
    always_comb
    begin
        logic [prvu_pkg::DEG_W-1:0] count_inc;

        state_next = state_reg;
        rank_next  = rank_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        flags_next = flags_reg;
        evt_next   = evt_reg;

        // Saturating count of received contributions.
        count_inc = (count_reg == {prvu_pkg::DEG_W{1'b1}}) ? count_reg : count_reg + 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    evt_next   = prvu_pkg::EVT_NONE;
                    state_next = S_DIV;
                    case (in_cmd)
                        prvu_pkg::CMD_RECEIVE:
                        begin
                            acc_next   = acc_reg + contribution;
                            count_next = count_inc;
                            if (count_inc >= in_degree_reg)
                            begin
                                flags_next.all_rcvd = 1'b1;
                                if (flags_reg.sent && !flags_reg.done)
                                begin
                                    flags_next.done = 1'b1;
                                    evt_next        = prvu_pkg::EVT_LOWER;
                                end
                            end
                        end
                        prvu_pkg::CMD_SEND:
                        begin
                            if (in_degree_reg != '0)
                            begin
                                flags_next.sent = 1'b1;
                                evt_next        = prvu_pkg::EVT_RAISE;
                                if (flags_reg.all_rcvd && !flags_reg.done)
                                begin
                                    flags_next.done = 1'b1;
                                    evt_next        = prvu_pkg::EVT_RAISE | prvu_pkg::EVT_LOWER;
                                end
                            end
                            else
                            begin
                                // No inputs to wait for: finish without an event.
                                flags_next.done = 1'b1;
                            end
                        end
                        prvu_pkg::CMD_END_ITER:
                        begin
                            state_next = S_MUL;
                        end
                        default:
                            ;
                    endcase
                end
            end
            S_MUL:
            begin
                if (mul_sts.done)
                begin
                    rank_next  = rank_sum;
                    acc_next   = '0;
                    count_next = '0;
                    flags_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rank_reg      <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            flags_reg     <= '0;
            evt_reg       <= prvu_pkg::EVT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rank_reg      <= rank_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            evt_reg       <= evt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register; the share passes rank through when out_degree is zero.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rank_out_reg  <= rank_reg;
            share_out_reg <= div_quot;
            flags_out_reg <= flags_reg;
            evt_out_reg   <= evt_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rank_value      = rank_out_reg;
    assign broadcast_share = share_out_reg;
    assign should_send     = !(flags_out_reg.done || flags_out_reg.sent);
    assign all_received    = flags_out_reg.all_rcvd;
    assign sent_flag       = flags_out_reg.sent;
    assign finished_flag   = flags_out_reg.done;
    assign semaphore_event = evt_out_reg;

`include "pagerank_vertex_update_assert.svh"

    `PRVU_ASSERT_NOW(a_idle_units_quiet, in_ready, !mul_sts.busy && !div_sts.busy, "input taken while a serial unit is busy")
    `PRVU_ASSERT_NEXT(a_mul_feeds_div, (state_reg == S_MUL) && mul_sts.done, div_sts.busy, "divider not started after multiply")
    `PRVU_ASSERT_NEXT(a_iter_clears, (state_reg == S_MUL) && mul_sts.done, (flags_reg == '0) && (acc_reg == '0) && (count_reg == '0), "end of iteration left state behind")
    `PRVU_ASSERT_NEXT(a_result_shown, (state_reg == S_DONE) && !out_valid_reg, out_valid_reg, "finished result not presented")

endmodule
